// ===== design/oarr_pkg.sv =====
// Shared types and constants for the ordered array block.
package oarr_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [1:0] {
      FN_DISPLAY = 2'd0,
      FN_INSERT  = 2'd1,
      FN_DELETE  = 2'd2,
      FN_SEARCH  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_BAD_POS   = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_FULL      = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHIFT,
      S_DRAIN,
      S_INS_PUT,
      S_SEARCH,
      S_SDRAIN,
      S_DISP_RD,
      S_DISP_WAIT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// ===== design/ordered_array_insert_delete_search.sv =====
// Top level: ordered list of signed 32-bit entries with insert, delete, search, display.
//
// Requests come in on the req_ channel (func, position, value) and results leave on
// the rsp_ channel (status, found_position, entry_value, last); both use valid/ready.
// req_ready is high only while the sequencer is idle; one request is worked at a time.
// All walks go through the entry memory (one read port and one write port, registered
// read data); shift and search walks read one entry per cycle:
//   insert  shifts the entries from position up, then writes; appending just writes
//   delete  shifts the entries above position down; no shift when the last entry goes
//   search  reads from the first entry and stops at the first match
//   display reads and sends one entry at a time, holding while rsp_ready is low
//   refused requests and the empty cases go straight to the result.
// Every request ends with a result flagged by rsp_last; display gives one result per
// entry. A finished result sits in the output register, so the next request can be
// taken while it waits; when rsp_ready is low the sequencer holds until the output
// register frees. Synchronous reset empties the list (count to zero) at once; the
// memory contents are not cleared and are never read before being written.
module ordered_array_insert_delete_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [oarr_pkg::POS_W-1:0]           req_position,
   input  logic signed [oarr_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic [oarr_pkg::POS_W-1:0]           rsp_found_position,
   output logic signed [oarr_pkg::DATA_W-1:0]   rsp_entry_value,
   output logic                                 rsp_last
);

   localparam int AW = oarr_pkg::ADDR_W;
   localparam int CW = oarr_pkg::CNT_W;
   localparam int MW = oarr_pkg::CMP_W;
   localparam int DW = oarr_pkg::DATA_W;
   localparam int PW = oarr_pkg::POS_W;

   oarr_pkg::state_type   state_ff, state_in;
   oarr_pkg::func_type    func_ff, func_in, req_fn;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         end_ff, end_in;
   logic [DW-1:0]         val_ff, val_in;
   logic                  rdv_ff, rdv_in;
   logic [AW-1:0]         rdaddr_ff, rdaddr_in;
   oarr_pkg::status_type  res_status_ff, res_status_in;
   logic [PW-1:0]         res_pos_ff, res_pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [PW-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [DW-1:0]         rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   oarr_pkg::mem_req_type mem_req;
   logic [DW-1:0]         rd_data;

   logic                  req_fire;
   logic                  out_free;
   logic                  load;
   logic [MW-1:0]         pos_ext, cnt_ext, pos_m1, cnt_m1, hit_pos;
   logic                  ins_bad, del_bad, full, hit, idx_end;

   oarr_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_fn   = oarr_pkg::func_type'(req_func);
   assign req_ready = (state_ff == oarr_pkg::S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign pos_ext = MW'(req_position);
   assign cnt_ext = MW'(cnt_ff);
   assign pos_m1  = pos_ext - MW'(1);
   assign cnt_m1  = cnt_ext - MW'(1);
   assign ins_bad = (pos_ext == '0) || (pos_ext > cnt_ext + MW'(1));
   assign del_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign full    = (cnt_ff == CW'(oarr_pkg::DEPTH));
   assign hit     = rdv_ff && (rd_data == val_ff);
   assign hit_pos = MW'(rdaddr_ff) + MW'(1);
   assign idx_end = (idx_ff == end_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oarr_pkg::S_IDLE: begin
            if (req_fire) begin
               unique case (req_fn)
                  oarr_pkg::FN_DISPLAY:
                     state_in = (cnt_ff == '0) ? oarr_pkg::S_RESULT : oarr_pkg::S_DISP_RD;
                  oarr_pkg::FN_INSERT: begin
                     if (ins_bad || full) begin
                        state_in = oarr_pkg::S_RESULT;
                     end else if (pos_m1 == cnt_ext) begin
                        state_in = oarr_pkg::S_INS_PUT;
                     end else begin
                        state_in = oarr_pkg::S_SHIFT;
                     end
                  end
                  oarr_pkg::FN_DELETE:
                     state_in = (del_bad || pos_ext == cnt_ext) ? oarr_pkg::S_RESULT
                                                                 : oarr_pkg::S_SHIFT;
                  oarr_pkg::FN_SEARCH:
                     state_in = (cnt_ff == '0) ? oarr_pkg::S_RESULT : oarr_pkg::S_SEARCH;
               endcase
            end
         end
         oarr_pkg::S_SHIFT:
            if (idx_end) state_in = oarr_pkg::S_DRAIN;
         oarr_pkg::S_DRAIN:
            state_in = (func_ff == oarr_pkg::FN_INSERT) ? oarr_pkg::S_INS_PUT
                                                        : oarr_pkg::S_RESULT;
         oarr_pkg::S_INS_PUT:
            state_in = oarr_pkg::S_RESULT;
         oarr_pkg::S_SEARCH: begin
            if (hit) begin
               state_in = oarr_pkg::S_RESULT;
            end else if (idx_end) begin
               state_in = oarr_pkg::S_SDRAIN;
            end
         end
         oarr_pkg::S_SDRAIN:
            state_in = oarr_pkg::S_RESULT;
         oarr_pkg::S_DISP_RD:
            state_in = oarr_pkg::S_DISP_WAIT;
         oarr_pkg::S_DISP_WAIT:
            if (out_free) state_in = idx_end ? oarr_pkg::S_IDLE : oarr_pkg::S_DISP_RD;
         oarr_pkg::S_RESULT:
            if (out_free) state_in = oarr_pkg::S_IDLE;
         default:
            state_in = oarr_pkg::S_IDLE;
      endcase
   end

   // datapath, memory requests and output loading
   always_comb begin
      func_in       = func_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      mem_req       = '0;
      load          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         oarr_pkg::S_IDLE: begin
            if (req_fire) begin
               func_in       = req_fn;
               val_in        = req_value;
               res_status_in = oarr_pkg::STS_OK;
               res_pos_in    = '0;
               unique case (req_fn)
                  oarr_pkg::FN_DISPLAY: begin
                     idx_in = '0;
                     end_in = cnt_m1[AW-1:0];
                     if (cnt_ff == '0) res_status_in = oarr_pkg::STS_EMPTY;
                  end
                  oarr_pkg::FN_INSERT: begin
                     idx_in = cnt_m1[AW-1:0];
                     end_in = pos_m1[AW-1:0];
                     if (ins_bad) begin
                        res_status_in = oarr_pkg::STS_BAD_POS;
                     end else if (full) begin
                        res_status_in = oarr_pkg::STS_FULL;
                     end
                  end
                  oarr_pkg::FN_DELETE: begin
                     // shift reads start one past the removed entry
                     idx_in = pos_ext[AW-1:0];
                     end_in = cnt_m1[AW-1:0];
                     if (del_bad) begin
                        res_status_in = oarr_pkg::STS_BAD_POS;
                     end else begin
                        cnt_in = cnt_ff - CW'(1);
                     end
                  end
                  oarr_pkg::FN_SEARCH: begin
                     idx_in = '0;
                     end_in = cnt_m1[AW-1:0];
                     if (cnt_ff == '0) res_status_in = oarr_pkg::STS_NOT_FOUND;
                  end
               endcase
            end
         end
         oarr_pkg::S_SHIFT: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff;
            idx_in = (func_ff == oarr_pkg::FN_INSERT) ? idx_ff - AW'(1) : idx_ff + AW'(1);
            mem_req.wr_en   = rdv_ff;
            mem_req.wr_data = rd_data;
            mem_req.wr_addr = (func_ff == oarr_pkg::FN_INSERT) ? rdaddr_ff + AW'(1)
                                                               : rdaddr_ff - AW'(1);
         end
         oarr_pkg::S_DRAIN: begin
            mem_req.wr_en   = rdv_ff;
            mem_req.wr_data = rd_data;
            mem_req.wr_addr = (func_ff == oarr_pkg::FN_INSERT) ? rdaddr_ff + AW'(1)
                                                               : rdaddr_ff - AW'(1);
         end
         oarr_pkg::S_INS_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = end_ff;
            mem_req.wr_data = val_ff;
            cnt_in          = cnt_ff + CW'(1);
         end
         oarr_pkg::S_SEARCH: begin
            if (hit) begin
               res_pos_in = hit_pos[PW-1:0];
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff;
               idx_in          = idx_ff + AW'(1);
            end
         end
         oarr_pkg::S_SDRAIN: begin
            if (hit) begin
               res_pos_in = hit_pos[PW-1:0];
            end else begin
               res_status_in = oarr_pkg::STS_NOT_FOUND;
            end
         end
         oarr_pkg::S_DISP_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff;
         end
         oarr_pkg::S_DISP_WAIT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = oarr_pkg::STS_OK;
               rsp_pos_in    = PW'(MW'(idx_ff) + MW'(1));
               rsp_value_in  = rd_data;
               rsp_last_in   = idx_end;
               idx_in        = idx_ff + AW'(1);
            end
         end
         oarr_pkg::S_RESULT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase

      rdv_in       = mem_req.rd_en;
      rdaddr_in    = mem_req.rd_addr;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oarr_pkg::S_IDLE;
         cnt_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      val_ff        <= val_in;
      rdaddr_ff     <= rdaddr_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_entry_value    = rsp_value_ff;
   assign rsp_last           = rsp_last_ff;

   // count never passes the store depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(oarr_pkg::DEPTH))
      else $error("entry count above depth");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_valid_ff) |-> rsp_ready)
      else $error("result register overwritten");

   // shifting never reads the entry it writes in the same cycle
   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("memory read and write collide");

   // writing the new entry grows the list by one
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oarr_pkg::S_INS_PUT) |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("insert did not bump count");

   // no request is taken while the sequencer is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != oarr_pkg::S_IDLE) |-> !req_fire)
      else $error("request taken while busy");

endmodule

// ===== design/oarr_store.sv =====
// Entry store: one write port, one read port with registered read data.
module oarr_store (
   input  logic                             clock,
   input  oarr_pkg::mem_req_type            mem_req,
   output logic [oarr_pkg::DATA_W-1:0]      rd_data
);

   logic [oarr_pkg::DATA_W-1:0] mem_ff [oarr_pkg::DEPTH];
   logic [oarr_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
